// File: rtl/drq_pkg.sv
// ----------------------------------------------------------------------------
// drq_pkg
// types, codes and sizes shared by the dirty rectangle queue modules
// ----------------------------------------------------------------------------
package drq_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int COORD_BITS  = 12;
  localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

  // action codes
  localparam logic [1:0] ACT_ADD  = 2'd0;
  localparam logic [1:0] ACT_SUB  = 2'd1;
  localparam logic [1:0] ACT_TAKE = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_SKIP  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } rect_t;

  typedef struct packed {
    logic [1:0] action;
    coord_t     rect_x;
    coord_t     rect_y;
    coord_t     rect_w;
    coord_t     rect_h;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                out_valid;
    coord_t              out_x;
    coord_t              out_y;
    coord_t              out_w;
    coord_t              out_h;
    logic [CNT_BITS-1:0] fill_count;
  } res_t;

  // port into the rectangle store
  typedef struct packed {
    logic                we;
    logic [IDX_BITS-1:0] waddr;
    rect_t               wdata;
    logic                re;
    logic [IDX_BITS-1:0] raddr;
  } store_req_t;

  // inclusion verdicts between the new rectangle and one stored entry
  typedef struct packed {
    logic new_holds_old;
    logic old_holds_new;
  } incl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_FINISH,
    S_RESULT
  } state_e;

endpackage

// File: rtl/drq_store.sv
// ----------------------------------------------------------------------------
// drq_store
// rectangle table memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module drq_store (
  input  logic                clk_i,
  input  drq_pkg::store_req_t req_i,
  output drq_pkg::rect_t      rdata_o
);

  drq_pkg::rect_t mem [drq_pkg::TABLE_DEPTH];
  drq_pkg::rect_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/drq_incl.sv
// ----------------------------------------------------------------------------
// drq_incl
// inclusion compare unit, both directions between two rectangles
// ----------------------------------------------------------------------------
module drq_incl (
  input  drq_pkg::rect_t new_i,
  input  drq_pkg::rect_t old_i,
  output drq_pkg::incl_t incl_o
);

  logic [drq_pkg::COORD_BITS:0] new_r, new_b, old_r, old_b;

  // right and bottom edges one bit wider so they never wrap
  assign new_r = {1'b0, new_i.x} + {1'b0, new_i.w};
  assign new_b = {1'b0, new_i.y} + {1'b0, new_i.h};
  assign old_r = {1'b0, old_i.x} + {1'b0, old_i.w};
  assign old_b = {1'b0, old_i.y} + {1'b0, old_i.h};

  assign incl_o.new_holds_old = (old_i.x >= new_i.x) && (old_i.y >= new_i.y) &&
                                (old_r <= new_r) && (old_b <= new_b);
  assign incl_o.old_holds_new = (new_i.x >= old_i.x) && (new_i.y >= old_i.y) &&
                                (new_r <= old_r) && (new_b <= old_b);

endmodule

// File: rtl/dirty_rect_queue.sv
// ----------------------------------------------------------------------------
// dirty_rect_queue
// ordered table of rectangles waiting for repaint: add, subtract, take
// ----------------------------------------------------------------------------
// an accepted start walks the stored entries in order: each entry is read
//   from memory in S_READ, then compared and written back in S_CHECK;
//   S_FINISH settles the result and S_RESULT raises the done strobe;
//   an empty table or an unused action code goes straight to S_FINISH
// busy stays high until the done strobe cycle ends; results cannot stall
// reset clears state, count, pointers and cover flag; contents are never read unwritten
module dirty_rect_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  drq_pkg::req_t req_i,
  output logic          done_o,
  output drq_pkg::res_t res_o
);

  localparam logic [drq_pkg::CNT_BITS-1:0] CntOne  = drq_pkg::CNT_BITS'(1);
  localparam logic [drq_pkg::CNT_BITS-1:0] CntFull = drq_pkg::CNT_BITS'(drq_pkg::TABLE_DEPTH);

  drq_pkg::state_e state_q, state_d;

  // latched command and walk pointers
  drq_pkg::req_t                 cmd_q, cmd_d;
  logic [drq_pkg::CNT_BITS-1:0]  rd_q, rd_d;
  logic [drq_pkg::CNT_BITS-1:0]  wr_q, wr_d;
  logic [drq_pkg::CNT_BITS-1:0]  count_q, count_d;
  logic                          covered_q, covered_d;
  drq_pkg::rect_t                taken_q, taken_d;
  drq_pkg::res_t                 res_q, res_d;

  drq_pkg::store_req_t store_req;
  drq_pkg::rect_t      rd_data;
  drq_pkg::rect_t      new_rect;
  drq_pkg::incl_t      incl;

  logic accept;
  logic last_entry;
  logic drop;

  assign accept   = start && !busy;
  assign new_rect = '{x: cmd_q.rect_x, y: cmd_q.rect_y, w: cmd_q.rect_w, h: cmd_q.rect_h};

  drq_store u_store (
    .clk_i  (clk_i),
    .req_i  (store_req),
    .rdata_o(rd_data)
  );

  drq_incl u_incl (
    .new_i (new_rect),
    .old_i (rd_data),
    .incl_o(incl)
  );

  assign last_entry = (rd_q + CntOne) == count_q;

  // a take drops the head; add and subtract drop what the new one includes,
  // but once an add has found a cover every remaining entry is kept
  always_comb begin
    if (covered_q) begin
      drop = 1'b0;
    end else if (cmd_q.action == drq_pkg::ACT_TAKE) begin
      drop = (rd_q == '0);
    end else begin
      drop = incl.new_holds_old;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      drq_pkg::S_IDLE: begin
        if (accept) begin
          // unused action code and an empty table skip the walk
          if ((count_q != '0) && (req_i.action inside
              {drq_pkg::ACT_ADD, drq_pkg::ACT_SUB, drq_pkg::ACT_TAKE})) begin
            state_d = drq_pkg::S_READ;
          end else begin
            state_d = drq_pkg::S_FINISH;
          end
        end
      end
      drq_pkg::S_READ: begin
        state_d = drq_pkg::S_CHECK;
      end
      drq_pkg::S_CHECK: begin
        if (last_entry) begin
          state_d = drq_pkg::S_FINISH;
        end else begin
          state_d = drq_pkg::S_READ;
        end
      end
      drq_pkg::S_FINISH: begin
        state_d = drq_pkg::S_RESULT;
      end
      drq_pkg::S_RESULT: begin
        state_d = drq_pkg::S_IDLE;
      end
      default: begin
        state_d = drq_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and store control
  always_comb begin
    cmd_d     = cmd_q;
    rd_d      = rd_q;
    wr_d      = wr_q;
    count_d   = count_q;
    covered_d = covered_q;
    taken_d   = taken_q;
    res_d     = res_q;
    store_req = '{we: 1'b0, waddr: wr_q[drq_pkg::IDX_BITS-1:0], wdata: rd_data,
                  re: 1'b0, raddr: rd_q[drq_pkg::IDX_BITS-1:0]};

    case (state_q)
      drq_pkg::S_IDLE: begin
        if (accept) begin
          cmd_d     = req_i;
          rd_d      = '0;
          wr_d      = '0;
          covered_d = 1'b0;
          taken_d   = '0;
        end
      end
      drq_pkg::S_READ: begin
        store_req.re = 1'b1;
      end
      drq_pkg::S_CHECK: begin
        // compact kept entries towards the head, order preserved
        if (!drop) begin
          store_req.we = 1'b1;
          wr_d         = wr_q + CntOne;
          if (!covered_q && cmd_q.action == drq_pkg::ACT_ADD && incl.old_holds_new) begin
            covered_d = 1'b1;
          end
        end
        if (cmd_q.action == drq_pkg::ACT_TAKE && rd_q == '0) begin
          taken_d = rd_data;
        end
        rd_d = rd_q + CntOne;
      end
      drq_pkg::S_FINISH: begin
        res_d = '0;
        case (cmd_q.action)
          drq_pkg::ACT_ADD: begin
            count_d = wr_q;
            if (covered_q) begin
              res_d.status = drq_pkg::ST_SKIP;
            end else if (wr_q >= CntFull) begin
              res_d.status = drq_pkg::ST_FULL;
            end else begin
              // append at the tail
              store_req.we    = 1'b1;
              store_req.wdata = new_rect;
              count_d         = wr_q + CntOne;
            end
          end
          drq_pkg::ACT_SUB: begin
            count_d = wr_q;
          end
          drq_pkg::ACT_TAKE: begin
            if (count_q == '0) begin
              res_d.status = drq_pkg::ST_EMPTY;
            end else begin
              count_d         = wr_q;
              res_d.out_valid = 1'b1;
              res_d.out_x     = taken_q.x;
              res_d.out_y     = taken_q.y;
              res_d.out_w     = taken_q.w;
              res_d.out_h     = taken_q.h;
            end
          end
          default: begin
            count_d = count_q;
          end
        endcase
        res_d.fill_count = count_d;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= drq_pkg::S_IDLE;
      count_q   <= '0;
      rd_q      <= '0;
      wr_q      <= '0;
      covered_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_q      <= rd_d;
      wr_q      <= wr_d;
      covered_q <= covered_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    taken_q <= taken_d;
    res_q   <= res_d;
  end

  assign busy   = (state_q != drq_pkg::S_IDLE);
  assign done_o = (state_q == drq_pkg::S_RESULT);
  assign res_o  = res_q;

endmodule
